// ----- sv/hrgb_pkg.sv -----
// hrgb_pkg: shared types, constants and palette for the hi-res row color decoder
`timescale 1ns / 1ps
package hrgb_pkg;

	localparam int ROW_DOTS = 14;
	localparam int BYTE_DOTS = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [3:0] LAST_INDEX = 4'd13;

	typedef enum logic [2:0] {
		COL_BLACK,
		COL_WHITE,
		COL_BLUE,
		COL_ORANGE,
		COL_GREEN,
		COL_VIOLET
	} color_t;

	typedef struct packed {
		color_t [ROW_DOTS-1:0] px;
		logic                  fin;
	} row_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic rgb_t color_rgb(input color_t c);
		rgb_t v;
		unique case (c)
			COL_BLACK:  v = '{r: 8'h00, g: 8'h00, b: 8'h00};
			COL_WHITE:  v = '{r: 8'hFF, g: 8'hFF, b: 8'hFF};
			COL_BLUE:   v = '{r: 8'h0D, g: 8'hA1, b: 8'hFF};
			COL_ORANGE: v = '{r: 8'hF2, g: 8'h5E, b: 8'h00};
			COL_GREEN:  v = '{r: 8'h38, g: 8'hCB, b: 8'h00};
			COL_VIOLET: v = '{r: 8'hC7, g: 8'h34, b: 8'hFF};
			default:    v = '{r: 8'h00, g: 8'h00, b: 8'h00};
		endcase
		return v;
	endfunction

endpackage

// ----- sv/hrgb_front.sv -----
// hrgb_front: takes a row request and classifies its fourteen dots into colors
`timescale 1ns / 1ps
module hrgb_front (
	input  logic              start,
	input  logic [7:0]        first_byte,
	input  logic [7:0]        second_byte,
	input  logic              final_row,
	input  hrgb_pkg::q_stat_t q_stat,
	output logic              busy,
	output logic              push,
	output hrgb_pkg::row_t    row
);

	logic [hrgb_pkg::ROW_DOTS+1:0] pad;
	logic [hrgb_pkg::ROW_DOTS-1:0] dots;

	assign dots = {second_byte[hrgb_pkg::BYTE_DOTS-1:0], first_byte[hrgb_pkg::BYTE_DOTS-1:0]};
	assign pad  = {1'b0, dots, 1'b0};
	assign busy = q_stat.full;
	assign push = start && !q_stat.full;

	always_comb begin
		logic l, m, r, pal;
		logic [1:0] pv;
		row.fin = final_row;
		for (int i = 0; i < hrgb_pkg::ROW_DOTS; i++) begin
			l   = pad[i];
			m   = pad[i+1];
			r   = pad[i+2];
			pal = (i < hrgb_pkg::BYTE_DOTS) ? first_byte[7] : second_byte[7];
			pv  = {dots[2*(i>>1)+1], dots[2*(i>>1)]};
			if (l == r && l != m) begin
				if (pv == 2'd1)
					row.px[i] = pal ? hrgb_pkg::COL_BLUE : hrgb_pkg::COL_VIOLET;
				else
					row.px[i] = pal ? hrgb_pkg::COL_ORANGE : hrgb_pkg::COL_GREEN;
			end else begin
				row.px[i] = m ? hrgb_pkg::COL_WHITE : hrgb_pkg::COL_BLACK;
			end
		end
	end

endmodule

// ----- sv/hrgb_queue.sv -----
// hrgb_queue: two-entry queue of classified rows between front and back
`timescale 1ns / 1ps
module hrgb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hrgb_pkg::row_t    wr_row,
	input  logic              pop,
	output hrgb_pkg::row_t    rd_row,
	output hrgb_pkg::q_stat_t q_stat
);

	localparam int PW = $clog2(hrgb_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(hrgb_pkg::QUEUE_DEPTH + 1);

	hrgb_pkg::row_t mem_q [hrgb_pkg::QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign rd_row       = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == CW'(hrgb_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(hrgb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(hrgb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_row;
	end

endmodule

// ----- sv/hrgb_back.sv -----
// hrgb_back: walks the head row pixel by pixel into registered rgb results
`timescale 1ns / 1ps
module hrgb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  hrgb_pkg::row_t    rd_row,
	input  hrgb_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              valid,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic [3:0]        pixel_index,
	output logic              last_pixel,
	output logic              end_of_data
);

	logic [3:0]   cnt_q;
	logic         go;
	logic         at_end;
	hrgb_pkg::rgb_t rgb;

	assign go     = !q_stat.empty;
	assign at_end = (cnt_q == hrgb_pkg::LAST_INDEX);
	assign pop    = go && at_end;
	assign rgb    = hrgb_pkg::color_rgb(rd_row.px[cnt_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			valid <= 1'b0;
		end else begin
			valid <= go;
			if (go)
				cnt_q <= at_end ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			red         <= rgb.r;
			green       <= rgb.g;
			blue        <= rgb.b;
			pixel_index <= cnt_q;
			last_pixel  <= at_end;
			end_of_data <= at_end && rd_row.fin;
		end
	end

endmodule

// ----- sv/hires_row_to_rgb_pixels.sv -----
// hires_row_to_rgb_pixels: top level of the hi-res row to rgb pixel decoder
//
//  channel  signals                                      handshake
//  request  first_byte, second_byte, final_row           start & !busy
//  result   red, green, blue, pixel_index, last_pixel,   valid, one cycle,
//           end_of_data                                  no back pressure
//
// one request yields 14 results on consecutive cycles, one per cycle from
// the back-end pixel counter; the row is written into the queue, and each
// result is registered in the back end; a two-row queue lets a new request
// enter while the previous row is emitted; busy is high while the queue holds
// two rows; reset empties the queue and clears valid
`timescale 1ns / 1ps
module hires_row_to_rgb_pixels (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] first_byte,
	input  logic [7:0] second_byte,
	input  logic       final_row,
	output logic       valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [3:0] pixel_index,
	output logic       last_pixel,
	output logic       end_of_data
);

	hrgb_pkg::q_stat_t q_stat;
	hrgb_pkg::row_t    wr_row, rd_row;
	logic              push, pop;

	hrgb_front u_front (
		.start       (start),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.final_row   (final_row),
		.q_stat      (q_stat),
		.busy        (busy),
		.push        (push),
		.row         (wr_row)
	);

	hrgb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_row (wr_row),
		.pop    (pop),
		.rd_row (rd_row),
		.q_stat (q_stat)
	);

	hrgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_row      (rd_row),
		.q_stat      (q_stat),
		.pop         (pop),
		.valid       (valid),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.pixel_index (pixel_index),
		.last_pixel  (last_pixel),
		.end_of_data (end_of_data)
	);

	a_pix_seq: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last_pixel |=> valid && pixel_index == $past(pixel_index) + 4'd1)
		else $error("pixel sequence broken inside a row");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (last_pixel == (pixel_index == hrgb_pkg::LAST_INDEX)))
		else $error("last_pixel does not match pixel_index");

	a_eod: assert property (@(posedge clk) disable iff (!arst_n)
		valid && end_of_data |-> last_pixel)
		else $error("end_of_data away from last pixel");

	a_start_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !$past(valid) |-> pixel_index == 4'd0)
		else $error("row emission began mid-row");

endmodule
